@@ hdl/ubdc_pkg.sv @@
// Package for the UART baud divisor calculator: payload structs, register
// indexes, status codes, prescaler shift tables and divider constants.
// No dependencies.
package ubdc_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SOURCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AHB_PRESCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APB1_PRESCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APB2_PRESCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLL_CLOCK = 3'd4;
  localparam int unsigned CFG_DATA_W = 27;

  // Clock source codes
  localparam logic [1:0] SRC_INTERNAL = 2'd0;
  localparam logic [1:0] SRC_EXTERNAL = 2'd1;
  localparam logic [1:0] SRC_PLL = 2'd2;
  localparam logic [1:0] SRC_INVALID = 2'd3;

  localparam logic [26:0] CLK_INTERNAL_HZ = 27'd16000000;
  localparam logic [26:0] CLK_EXTERNAL_HZ = 27'd8000000;

  // Status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAUD_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD_SOURCE = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // Divider geometry: 32-bit dividend, 26-bit divisor, 20 quotient bits
  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 26;
  localparam int unsigned QUO_W = 20;
  localparam int unsigned DIV_STEPS = 5;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  // q / 100 as (q * MANT_RECIP) >> MANT_SHIFT, exact for q < 2^20
  localparam logic [19:0] MANT_RECIP = 20'd671089;
  localparam int unsigned MANT_SHIFT = 26;
  localparam logic [13:0] MANTISSA_MAX = 14'd4095;

  // v / 100 as (v * FRAC_RECIP) >> FRAC_SHIFT, exact for v < 2048
  localparam logic [10:0] FRAC_RECIP = 11'd1311;
  localparam int unsigned FRAC_SHIFT = 17;

  typedef struct packed {
    logic [23:0] baud_rate;
    logic        oversample_by_8;
    logic        on_fast_bus;
  } in_word_t;

  typedef struct packed {
    logic [15:0] divisor_word;
    logic [11:0] mantissa;
    logic [3:0]  fraction;
    logic [1:0]  status;
  } out_word_t;

  // Side information that rides along with each word through the pipe
  typedef struct packed {
    logic       over8;
    logic [1:0] status;
    logic       ovf;
  } side_t;

  // AHB divisors 2,4,8,16,64,128,256,512 as shift amounts
  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  // APB divisors 2,4,8,16 as shift amounts
  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] sh;
    unique case (code)
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd3;
      3'd7:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

@@ hdl/uart_baud_divisor_calc_top.sv @@
// Top level of the UART baud divisor calculator: config registers, clock
// derivation, divider pipeline and mantissa/fraction split.
// Depends on ubdc_pkg and ubdc_div_stage.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_word_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (out_word_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word enters per cycle unless a stalled output has backed up to the
// input; each result passes through nine register stages: clock select, x25,
// four divider stages of five quotient bits each, mantissa reciprocal
// multiply, remainder, and fraction rounding into the output register.
// Reset clears the valid bits and the config registers; payload holds none.
// Each stage advances when empty or when the stage after it advances, so
// a stalled output lets bubbles close up and nothing is dropped or repeated.
// The config port never stalls.
module uart_baud_divisor_calc_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ubdc_pkg::in_word_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ubdc_pkg::out_word_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ubdc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned NSTG = 9;
  localparam int unsigned DIV_FIRST = 2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]  clock_source_q;
  logic [3:0]  ahb_code_q;
  logic [2:0]  apb1_code_q;
  logic [2:0]  apb2_code_q;
  logic [26:0] pll_hz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_source_q <= ubdc_pkg::SRC_INTERNAL;
      ahb_code_q     <= '0;
      apb1_code_q    <= '0;
      apb2_code_q    <= '0;
      pll_hz_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ubdc_pkg::REG_CLOCK_SOURCE:  clock_source_q <= cfg_data_i[1:0];
        ubdc_pkg::REG_AHB_PRESCALE:  ahb_code_q     <= cfg_data_i[3:0];
        ubdc_pkg::REG_APB1_PRESCALE: apb1_code_q    <= cfg_data_i[2:0];
        ubdc_pkg::REG_APB2_PRESCALE: apb2_code_q    <= cfg_data_i[2:0];
        ubdc_pkg::REG_PLL_CLOCK:     pll_hz_q       <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) vld_d[0] = in_valid_i;
    for (int i = 1; i < NSTG; i++) begin
      if (adv[i]) vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTG-1];

  // ---------------------------------------------------------------------
  // Stage 0: pick the system clock, apply both prescalers as one shift,
  // build the divisor (2*baud or 4*baud) and flag the early errors
  // ---------------------------------------------------------------------
  logic [26:0]                   sysclk;
  logic [3:0]                    pre_shift;
  logic [26:0]                   pclk0_d;
  logic [ubdc_pkg::DEN_W-1:0]    den0_d;
  ubdc_pkg::side_t               side0_d;
  logic [26:0]                   pclk0_q;
  logic [ubdc_pkg::DEN_W-1:0]    den0_q;
  ubdc_pkg::side_t               side0_q;

  always_comb begin
    unique case (clock_source_q)
      ubdc_pkg::SRC_INTERNAL: sysclk = ubdc_pkg::CLK_INTERNAL_HZ;
      ubdc_pkg::SRC_EXTERNAL: sysclk = ubdc_pkg::CLK_EXTERNAL_HZ;
      ubdc_pkg::SRC_PLL:      sysclk = pll_hz_q;
      default:                sysclk = '0;
    endcase
    pre_shift = ubdc_pkg::ahb_shift(ahb_code_q)
              + {1'b0, ubdc_pkg::apb_shift(in_data_i.on_fast_bus ? apb2_code_q
                                                                 : apb1_code_q)};
    pclk0_d = sysclk >> pre_shift;
    den0_d  = in_data_i.oversample_by_8 ? {1'b0, in_data_i.baud_rate, 1'b0}
                                        : {in_data_i.baud_rate, 2'b00};
    side0_d.over8 = in_data_i.oversample_by_8;
    side0_d.ovf   = 1'b0;
    // Zero baud outranks a bad clock source
    priority if (in_data_i.baud_rate == '0) begin
      side0_d.status = ubdc_pkg::ST_BAUD_ZERO;
    end else if (clock_source_q == ubdc_pkg::SRC_INVALID) begin
      side0_d.status = ubdc_pkg::ST_BAD_SOURCE;
    end else begin
      side0_d.status = ubdc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pclk0_q <= pclk0_d;
      den0_q  <= den0_d;
      side0_q <= side0_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: dividend = 25 * pclk, fits in 32 bits for any 27-bit clock
  // ---------------------------------------------------------------------
  logic [ubdc_pkg::NUM_W-1:0]    num1_d;
  logic [ubdc_pkg::NUM_W-1:0]    num1_q;
  logic [ubdc_pkg::DEN_W-1:0]    den1_q;
  ubdc_pkg::side_t               side1_q;

  assign num1_d = {1'b0, pclk0_q, 4'b0000} + {2'b00, pclk0_q, 3'b000}
                + {5'b00000, pclk0_q};

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      num1_q  <= num1_d;
      den1_q  <= den0_q;
      side1_q <= side0_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2..5: restoring divider. A quotient of 2^20 or more is far past
  // mantissa saturation, so only 20 quotient bits are formed and the rest
  // is caught by one compare up front.
  // ---------------------------------------------------------------------
  localparam int unsigned HI_W = ubdc_pkg::NUM_W - ubdc_pkg::QUO_W;

  logic [ubdc_pkg::DEN_W-1:0] div_den [ubdc_pkg::DIV_STAGES+1];
  logic [ubdc_pkg::DEN_W-1:0] div_rem [ubdc_pkg::DIV_STAGES+1];
  logic [ubdc_pkg::QUO_W-1:0] div_num [ubdc_pkg::DIV_STAGES+1];
  logic [ubdc_pkg::QUO_W-1:0] div_quo [ubdc_pkg::DIV_STAGES+1];
  ubdc_pkg::side_t            div_side [ubdc_pkg::DIV_STAGES+1];

  assign div_den[0] = den1_q;
  assign div_rem[0] = {{(ubdc_pkg::DEN_W-HI_W){1'b0}},
                       num1_q[ubdc_pkg::NUM_W-1:ubdc_pkg::QUO_W]};
  assign div_num[0] = num1_q[ubdc_pkg::QUO_W-1:0];
  assign div_quo[0] = '0;
  assign div_side[0] = '{
    over8:  side1_q.over8,
    status: side1_q.status,
    ovf:    ({{ubdc_pkg::DEN_W{1'b0}}, num1_q[ubdc_pkg::NUM_W-1:0]}
             >= {{HI_W{1'b0}}, den1_q, {ubdc_pkg::QUO_W{1'b0}}})
  };

  for (genvar g = 0; g < ubdc_pkg::DIV_STAGES; g++) begin : g_div
    ubdc_div_stage u_stage (
      .clk_i  (clk_i),
      .en_i   (adv[DIV_FIRST+g]),
      .den_i  (div_den[g]),
      .rem_i  (div_rem[g]),
      .num_i  (div_num[g]),
      .quo_i  (div_quo[g]),
      .side_i (div_side[g]),
      .den_o  (div_den[g+1]),
      .rem_o  (div_rem[g+1]),
      .num_o  (div_num[g+1]),
      .quo_o  (div_quo[g+1]),
      .side_o (div_side[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 6: mantissa = usartdiv / 100 by reciprocal multiply
  // ---------------------------------------------------------------------
  logic [ubdc_pkg::QUO_W-1:0] quo_last;
  logic [39:0]                mant_prod;
  logic [13:0]                mant6_q;
  logic [ubdc_pkg::QUO_W-1:0] quo6_q;
  ubdc_pkg::side_t            side6_q;

  assign quo_last  = div_quo[ubdc_pkg::DIV_STAGES];
  assign mant_prod = quo_last * ubdc_pkg::MANT_RECIP;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      mant6_q <= mant_prod[ubdc_pkg::MANT_SHIFT+13:ubdc_pkg::MANT_SHIFT];
      quo6_q  <= quo_last;
      side6_q <= div_side[ubdc_pkg::DIV_STAGES];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: remainder mod 100, saturate the mantissa
  // ---------------------------------------------------------------------
  logic [ubdc_pkg::QUO_W-1:0] rem_full;
  logic                       sat7;
  logic [6:0]                 rem7_q;
  logic [11:0]                mant7_q;
  ubdc_pkg::side_t            side7_d;
  ubdc_pkg::side_t            side7_q;

  always_comb begin
    rem_full = quo6_q - ({{(ubdc_pkg::QUO_W-14){1'b0}}, mant6_q}
                         * ubdc_pkg::QUO_W'(100));
    sat7     = side6_q.ovf || (mant6_q > ubdc_pkg::MANTISSA_MAX);
    side7_d  = side6_q;
    if (side6_q.status == ubdc_pkg::ST_OK && sat7) begin
      side7_d.status = ubdc_pkg::ST_SATURATED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      rem7_q  <= rem_full[6:0];
      mant7_q <= sat7 ? ubdc_pkg::MANTISSA_MAX[11:0] : mant6_q[11:0];
      side7_q <= side7_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8 (output register): round the fraction, mask it to the mode,
  // zero the fields on errors and pack the divisor word
  // ---------------------------------------------------------------------
  logic [10:0]         frac_num;
  logic [21:0]         frac_prod;
  logic [3:0]          frac_raw;
  ubdc_pkg::out_word_t out_d;
  ubdc_pkg::out_word_t out_q;

  always_comb begin
    frac_num  = side7_q.over8 ? ({1'b0, rem7_q, 3'b000} + 11'd50)
                              : ({rem7_q, 4'b0000} + 11'd50);
    frac_prod = frac_num * ubdc_pkg::FRAC_RECIP;
    frac_raw  = frac_prod[ubdc_pkg::FRAC_SHIFT+3:ubdc_pkg::FRAC_SHIFT];
    out_d.status = side7_q.status;
    unique case (side7_q.status)
      ubdc_pkg::ST_OK: begin
        out_d.mantissa = mant7_q;
        out_d.fraction = side7_q.over8 ? {1'b0, frac_raw[2:0]} : frac_raw;
      end
      ubdc_pkg::ST_SATURATED: begin
        out_d.mantissa = mant7_q;
        out_d.fraction = side7_q.over8 ? 4'h7 : 4'hF;
      end
      default: begin
        out_d.mantissa = '0;
        out_d.fraction = '0;
      end
    endcase
    out_d.divisor_word = {out_d.mantissa, out_d.fraction};
  end

  always_ff @(posedge clk_i) begin
    if (adv[NSTG-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hdl/ubdc_div_stage.sv @@
// One registered stage of the restoring divider: DIV_STEPS quotient bits.
// Depends on ubdc_pkg.
module ubdc_div_stage (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ubdc_pkg::DEN_W-1:0]    den_i,
  input  logic [ubdc_pkg::DEN_W-1:0]    rem_i,
  input  logic [ubdc_pkg::QUO_W-1:0]    num_i,
  input  logic [ubdc_pkg::QUO_W-1:0]    quo_i,
  input  ubdc_pkg::side_t               side_i,
  output logic [ubdc_pkg::DEN_W-1:0]    den_o,
  output logic [ubdc_pkg::DEN_W-1:0]    rem_o,
  output logic [ubdc_pkg::QUO_W-1:0]    num_o,
  output logic [ubdc_pkg::QUO_W-1:0]    quo_o,
  output ubdc_pkg::side_t               side_o
);

  logic [ubdc_pkg::DEN_W-1:0] rem_d;
  logic [ubdc_pkg::QUO_W-1:0] num_d;
  logic [ubdc_pkg::QUO_W-1:0] quo_d;
  logic [ubdc_pkg::DEN_W:0]   trial;

  // Shift in the next dividend bit, subtract where the divisor fits
  always_comb begin
    rem_d = rem_i;
    num_d = num_i;
    quo_d = quo_i;
    trial = '0;
    for (int i = 0; i < ubdc_pkg::DIV_STEPS; i++) begin
      trial = {rem_d, num_d[ubdc_pkg::QUO_W-1]};
      num_d = {num_d[ubdc_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = ubdc_pkg::DEN_W'(trial - {1'b0, den_i});
        quo_d = {quo_d[ubdc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[ubdc_pkg::DEN_W-1:0];
        quo_d = {quo_d[ubdc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o  <= den_i;
      rem_o  <= rem_d;
      num_o  <= num_d;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

@@ hdl/ubdc_checker.sv @@
// Port-level checker for the UART baud divisor calculator, bound to the top.
// Depends on ubdc_pkg and uart_baud_divisor_calc_top.
module ubdc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ubdc_pkg::out_word_t out_data_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.divisor_word
                    == {out_data_o.mantissa, out_data_o.fraction})
    else $error("divisor word does not match mantissa and fraction");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ubdc_pkg::ST_SATURATED
      |-> out_data_o.mantissa == 12'hFFF
          && (out_data_o.fraction == 4'hF || out_data_o.fraction == 4'h7))
    else $error("saturated result not at full scale");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ubdc_pkg::ST_BAUD_ZERO
                    || out_data_o.status == ubdc_pkg::ST_BAD_SOURCE)
      |-> out_data_o.divisor_word == 16'h0000)
    else $error("error result carries a nonzero divisor");

endmodule

bind uart_baud_divisor_calc_top ubdc_checker u_ubdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
